// ----- sv/lfk_pkg.sv -----
package lfk_pkg;

	localparam int ID_W  = 10;
	localparam int CNT_W = 31;
	localparam int LIM_W = 5;

	localparam int NUM_IDS_DEF = 1024;
	localparam int MAX_K_DEF   = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] CMD_INC   = 2'd0;
	localparam logic [1:0] CMD_SETTOP = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [ID_W-1:0]  value_id;
		logic [LIM_W-1:0] limit;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0]  label_id;
		logic [CNT_W-1:0] label_count;
		logic             last;
	} out_t;

endpackage

// ----- sv/label_frequency_top_k_unit.sv -----
// Label frequency counter with a running leader and a top-K query.
// Input channel cmd/cmd_valid/cmd_stall carries commands: increment an id,
// pin or unpin the leader, or query up to limit labels. Results leave on
// res/res_valid/res_stall, one label per transfer, last set on the final
// transfer of a query. Commands that give nothing produce no transfer.
// Counts live in one single-port-read synchronous memory of NUM_IDS words.
// After reset the block clears that memory, one word a cycle, and holds
// cmd_stall high until the clear is done, before the first command is taken.
// Command steps, paced by the memory's registered read:
//   increment: read, then write back; pin or no-op: no table walk;
//   unpin: a full table walk;
//   query with limit 1: the leader, if any, is reported alone;
//   query with limit K > 1: one table walk per reported label (plus one
//   walk if the table runs out), then a flush, and a pin step first when
//   a pinned id leads the list.
// A result register sits at the output; while res_stall is high the block
// holds the result and waits before pushing the next one, and it takes no
// new command until the running query has pushed its last transfer.
module label_frequency_top_k_unit #(
	parameter int NUM_IDS = lfk_pkg::NUM_IDS_DEF,
	parameter int MAX_K   = lfk_pkg::MAX_K_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  lfk_pkg::in_t  cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output lfk_pkg::out_t res
);

	localparam int AW = $clog2(NUM_IDS);
	localparam int KW = $clog2(MAX_K + 1);
	localparam int IW = lfk_pkg::ID_W;
	localparam int CW = lfk_pkg::CNT_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_IDS - 1);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_INC   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_PIN   = 3'd4;
	localparam logic [2:0] S_QSCAN = 3'd5;
	localparam logic [2:0] S_QNEXT = 3'd6;
	localparam logic [2:0] S_FLUSH = 3'd7;

	logic [CW-1:0] mem [NUM_IDS];

	logic [2:0]    state_q;
	logic [AW-1:0] idx_q;
	logic          issuing_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [CW-1:0] rd_data_s1;
	logic [AW-1:0] inc_addr_q;
	logic [IW-1:0] leader_id_q;
	logic [CW-1:0] leader_count_q;
	logic          pinned_q;
	logic          one_q;
	logic [KW-1:0] slots_q;
	logic          found_q;
	logic [CW-1:0] bc_q;
	logic [IW-1:0] bi_q;
	logic          bound_inf_q;
	logic [CW-1:0] bound_c_q;
	logic [IW-1:0] bound_i_q;
	logic          pend_vld_q;
	lfk_pkg::out_t pend_q;
	logic          out_vld_q;
	lfk_pkg::out_t out_q;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wa;
	logic [CW-1:0] wd;
	logic [CW-1:0] inc_cnt;
	logic [IW-1:0] ci;
	logic          below_bound;
	logic          better;
	logic          take;
	logic          scan_end;
	logic          id_in_range;
	logic [KW-1:0] lim_sat;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !out_vld_q || !res_stall;
	assign res_valid = out_vld_q;
	assign res       = out_q;

	// pending label moves to the output register
	assign out_load = pend_vld_q && out_free &&
		(((state_q == S_QNEXT) && found_q) || (state_q == S_FLUSH));

	assign id_in_range = (32'(cmd.value_id) < NUM_IDS);
	assign lim_sat = (32'(cmd.limit) > MAX_K) ? KW'(MAX_K) : KW'(cmd.limit);

	assign inc_cnt = (rd_data_s1 == lfk_pkg::CNT_MAX) ? rd_data_s1 : rd_data_s1 + 1'b1;

	// candidate ranking for one query walk: strictly below the last reported
	// label, better than the best seen so far (count, then larger id)
	assign ci = IW'(rd_idx_s1);
	assign below_bound = bound_inf_q || (bound_c_q > rd_data_s1) ||
		((bound_c_q == rd_data_s1) && (bound_i_q > ci));
	assign better = !found_q || (rd_data_s1 > bc_q) || ((rd_data_s1 == bc_q) && (ci > bi_q));
	assign take = rd_vld_s1 && (rd_data_s1 != '0) && !(pinned_q && (ci == leader_id_q)) &&
		below_bound && better;
	assign scan_end = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_IDLE) begin
			if (cmd.command == lfk_pkg::CMD_INC)
				rd_addr = AW'(cmd.value_id);
			else
				rd_addr = AW'(leader_id_q);
		end
	end

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = '0;
		if (state_q == S_CLR) begin
			we = 1'b1;
		end else if (state_q == S_INC) begin
			we = 1'b1;
			wa = inc_addr_q;
			wd = inc_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			idx_q          <= '0;
			issuing_q      <= 1'b0;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			inc_addr_q     <= '0;
			leader_id_q    <= '0;
			leader_count_q <= '0;
			pinned_q       <= 1'b0;
			one_q          <= 1'b0;
			slots_q        <= '0;
			found_q        <= 1'b0;
			bc_q           <= '0;
			bi_q           <= '0;
			bound_inf_q    <= 1'b1;
			bound_c_q      <= '0;
			bound_i_q      <= '0;
			pend_vld_q     <= 1'b0;
			pend_q         <= '0;
			out_vld_q      <= 1'b0;
			out_q          <= '0;
		end else begin
			if (out_load)
				out_vld_q <= 1'b1;
			else if (!res_stall)
				out_vld_q <= 1'b0;

			// read issue pipeline for table walks
			rd_vld_s1 <= (state_q == S_SCAN || state_q == S_QSCAN) && issuing_q;
			if ((state_q == S_SCAN || state_q == S_QSCAN) && issuing_q) begin
				rd_idx_s1 <= idx_q;
				idx_q     <= idx_q + 1'b1;
				if (idx_q == LAST_IDX)
					issuing_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
					if (idx_q == LAST_IDX)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						case (cmd.command)
							lfk_pkg::CMD_INC: begin
								if (id_in_range) begin
									inc_addr_q <= AW'(cmd.value_id);
									state_q    <= S_INC;
								end
							end
							lfk_pkg::CMD_SETTOP: begin
								if (cmd.value_id != '0) begin
									if (id_in_range) begin
										leader_id_q    <= cmd.value_id;
										leader_count_q <= '0;
										pinned_q       <= 1'b1;
									end
								end else if (pinned_q) begin
									pinned_q       <= 1'b0;
									leader_id_q    <= '0;
									leader_count_q <= '0;
									idx_q          <= '0;
									issuing_q      <= 1'b1;
									state_q        <= S_SCAN;
								end
							end
							lfk_pkg::CMD_QUERY: begin
								bound_inf_q <= 1'b1;
								slots_q     <= lim_sat;
								one_q       <= (lim_sat == KW'(1));
								if (lim_sat == KW'(1)) begin
									if (leader_id_q != '0)
										state_q <= S_PIN;
								end else if (lim_sat != '0) begin
									if (pinned_q) begin
										state_q <= S_PIN;
									end else begin
										idx_q     <= '0;
										issuing_q <= 1'b1;
										found_q   <= 1'b0;
										state_q   <= S_QSCAN;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_INC: begin
					if (!pinned_q && (inc_cnt > leader_count_q)) begin
						leader_id_q    <= IW'(inc_addr_q);
						leader_count_q <= inc_cnt;
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (rd_vld_s1 && (rd_data_s1 > leader_count_q)) begin
						leader_id_q    <= ci;
						leader_count_q <= rd_data_s1;
					end
					if (scan_end)
						state_q <= S_IDLE;
				end
				S_PIN: begin
					pend_vld_q           <= 1'b1;
					pend_q.label_id      <= leader_id_q;
					pend_q.label_count   <= pinned_q ? rd_data_s1 : leader_count_q;
					pend_q.last          <= 1'b0;
					if (one_q) begin
						state_q <= S_FLUSH;
					end else begin
						slots_q   <= slots_q - 1'b1;
						idx_q     <= '0;
						issuing_q <= 1'b1;
						found_q   <= 1'b0;
						state_q   <= S_QSCAN;
					end
				end
				S_QSCAN: begin
					if (take) begin
						found_q <= 1'b1;
						bc_q    <= rd_data_s1;
						bi_q    <= ci;
					end
					if (scan_end)
						state_q <= S_QNEXT;
				end
				S_QNEXT: begin
					if (!found_q) begin
						state_q <= S_FLUSH;
					end else if (!pend_vld_q || out_free) begin
						if (pend_vld_q)
							out_q <= pend_q;
						pend_vld_q         <= 1'b1;
						pend_q.label_id    <= bi_q;
						pend_q.label_count <= bc_q;
						pend_q.last        <= 1'b0;
						bound_inf_q        <= 1'b0;
						bound_c_q          <= bc_q;
						bound_i_q          <= bi_q;
						slots_q            <= slots_q - 1'b1;
						if (slots_q == KW'(1)) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q     <= '0;
							issuing_q <= 1'b1;
							found_q   <= 1'b0;
							state_q   <= S_QSCAN;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_vld_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q      <= {pend_q.label_id, pend_q.label_count, 1'b1};
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a pinned leader is always a real id
	a_pin_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pinned_q |-> (leader_id_q != '0))
		else $error("pinned leader with id zero");

	// table reads only come back during a walk or its final cycle
	a_rd_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN || state_q == S_QSCAN))
		else $error("read data outside a table walk");

	// no result is left behind when a command finishes
	a_pend_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_vld_q)
		else $error("pending result left in idle");

	// an increment write follows its read directly
	a_inc_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INC) |-> ($past(state_q) == S_IDLE))
		else $error("increment write without read");

endmodule
